// ----- rtl/kce_pkg.sv -----
// ----------------------------------------------------------------------------
// kce_pkg - shared types and constants of the keyframe curve evaluator
// Key record, sequencer states, register indexes, curve and clamp codes.
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_IDX_W = $clog2(MAX_KEYS);
    localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

    // Fraction bits of the segment parameter t
    localparam int T_FRAC    = 30;
    localparam int DIV_CNT_W = $clog2(T_FRAC);

    // Stream and configuration widths
    localparam int S_TDATA_W  = 136;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KIND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CLAMP = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    localparam logic [1:0] KIND_STEP    = 2'd1;
    localparam logic [1:0] KIND_HERMITE = 2'd2;

    localparam logic [1:0] CLAMP_U8  = 2'd1;
    localparam logic [1:0] CLAMP_S11 = 2'd2;

    typedef struct packed {
        logic signed [31:0] frame;
        logic signed [31:0] value;
        logic signed [31:0] slope;
    } t_key;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DIV,
        S_T2,
        S_T3,
        S_H,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_SUM,
        S_FIN
    } t_state;

endpackage

// ----- rtl/kce_key_cell.sv -----
// ----------------------------------------------------------------------------
// kce_key_cell - one key slot of the key ring
// Holds one key; loads a written key or takes its neighbor's key on a shift.
// ----------------------------------------------------------------------------
module kce_key_cell (
    input  logic          i_clk,
    input  logic          i_wr,
    input  kce_pkg::t_key i_wr_key,
    input  logic          i_shift,
    input  kce_pkg::t_key i_next_key,
    output kce_pkg::t_key o_key
);
    import kce_pkg::*;

    t_key r_key;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_key <= i_wr_key;
        end else if (i_shift) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;

endmodule

// ----- rtl/kce_divider.sv -----
// ----------------------------------------------------------------------------
// kce_divider - restoring divider for the segment parameter
// Computes (num << T_FRAC) / den for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kce_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_num,
    input  logic [31:0]                i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [kce_pkg::T_FRAC-1:0] o_quot
);
    import kce_pkg::*;

    logic [31:0]          r_rem;
    logic [31:0]          r_den;
    logic [T_FRAC-1:0]    r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [32:0]          w_shl;
    logic [32:0]          w_diff;
    logic                 w_fit;

    assign w_shl  = {r_rem, 1'b0};
    assign w_diff = w_shl - {1'b0, r_den};
    assign w_fit  = (w_shl >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(T_FRAC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder stays below the divisor, so it fits 32 bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[31:0] : w_shl[31:0];
            r_quot <= {r_quot[T_FRAC-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/keyframe_curve_evaluator_unit.sv -----
// Sequence: a key write gives no result. An evaluation scans the key ring
// past the scan head, then takes one decision step; step, none and edge cases
// then load the result, while an interior Hermite segment first runs the
// divider and the multiply steps (S_T2 through S_SUM) before the load.
// One item is worked at a time; the next is taken in the cycle after the load.
// Reset (synchronous, active low) clears config, sequencer and output valid.
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator_unit - keyframe curve evaluator
// Stores keys in a ring of cells, rotates them past a scan head to find the
// active segment, then evaluates a step or cubic Hermite curve in fixed point
// with a shared multiplier and an optional integer output clamp.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata from bit 0: key_index[5:0], new_key_frame[37:6],
    // new_key_value[69:38], new_key_slope[101:70], query_frame[133:102], zero pad
    input  logic [kce_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: action[0]
    input  logic [0:0]                    i_s_tuser,
    // Result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: curve_value[31:0]
    output logic [31:0]                   o_m_tdata,
    // tuser: clamped[0]
    output logic [0:0]                    o_m_tuser,
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kce_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kce_pkg::*;

    localparam logic signed [47:0] LIM_U8_HI  = 48'sd16711680;   // 255 in Q16.16
    localparam logic signed [47:0] LIM_S11_HI = 48'sd67043328;   // 1023 in Q16.16
    localparam logic signed [47:0] LIM_S11_LO = -48'sd67108864;  // -1024 in Q16.16
    localparam logic signed [47:0] LIM_RAW_HI = 48'sd2147483647;
    localparam logic signed [47:0] LIM_RAW_LO = -48'sd2147483648;

    // ------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------
    logic [5:0]         w_key_index;
    t_key               w_wr_key;
    logic signed [31:0] w_query;
    logic               w_acc;
    logic               w_wr_en;

    assign w_key_index    = i_s_tdata[5:0];
    assign w_wr_key.frame = i_s_tdata[37:6];
    assign w_wr_key.value = i_s_tdata[69:38];
    assign w_wr_key.slope = i_s_tdata[101:70];
    assign w_query        = i_s_tdata[133:102];

    assign w_acc   = i_s_tvalid && o_s_tready;
    assign w_wr_en = w_acc && (i_s_tuser[0] == ACT_WRITE);

    // ------------------------------------------------------------------
    // Configuration registers; writes to an unknown index are dropped
    // ------------------------------------------------------------------
    logic [6:0] r_key_count;
    logic [1:0] r_kind;
    logic [1:0] r_clamp_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count  <= '0;
            r_kind       <= '0;
            r_clamp_mode <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_COUNT:    r_key_count  <= i_cfg_data[6:0];
                CFG_CURVE_KIND:   r_kind       <= i_cfg_data[1:0];
                CFG_OUTPUT_CLAMP: r_clamp_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective key count, capped at the ring size
    logic [KEY_CNT_W-1:0] w_n;
    assign w_n = (32'(r_key_count) > MAX_KEYS) ? KEY_CNT_W'(MAX_KEYS)
                                               : KEY_CNT_W'(r_key_count);

    // ------------------------------------------------------------------
    // Key ring: every cell hands its key to the cell below on a shift,
    // cell 0 is the scan head. A full scan is MAX_KEYS shifts, so the
    // ring is back in slot order when the block is idle again.
    // ------------------------------------------------------------------
    t_key w_keys [MAX_KEYS];
    logic w_shift;

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        kce_key_cell u_cell (
            .i_clk      (i_clk),
            .i_wr       (w_wr_en && (32'(w_key_index) == 32'(g))),
            .i_wr_key   (w_wr_key),
            .i_shift    (w_shift),
            .i_next_key (w_keys[(g + 1) % MAX_KEYS]),
            .o_key      (w_keys[g])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [KEY_IDX_W-1:0] r_scan_k;
    logic                 w_need_div;
    logic                 w_div_start;
    logic                 w_div_busy;
    logic                 w_div_done;
    logic [T_FRAC-1:0]    w_div_quot;
    logic                 w_load;
    logic                 r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        w_shift     = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid && (i_s_tuser[0] == ACT_EVAL)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_shift = 1'b1;
                if (r_scan_k == KEY_IDX_W'(MAX_KEYS - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_need_div) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_T2;
                end
            end
            S_T2:  n_state = S_T3;
            S_T3:  n_state = S_H;
            S_H:   n_state = S_M1;
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_M3;
            S_M3:  n_state = S_M4;
            S_M4:  n_state = S_M5;
            S_M5:  n_state = S_M6;
            S_M6:  n_state = S_SUM;
            S_SUM: n_state = S_FIN;
            S_FIN: begin
                // Hold the result until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_k <= '0;
        end else if (w_shift) begin
            r_scan_k <= r_scan_k + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Scan head: keys pass in slot order, key k at step k
    // ------------------------------------------------------------------
    logic signed [31:0] r_q;
    logic signed [31:0] r_stepv;
    logic               r_brk;
    logic               r_found;
    t_key               r_key0;
    t_key               r_last;
    t_key               r_prev;
    t_key               r_seg0;
    t_key               r_seg1;
    t_key               w_head;
    logic [KEY_CNT_W:0] w_kx;
    logic [KEY_CNT_W:0] w_nx;
    logic               w_in_range;
    logic               w_is_last;
    logic               w_below;

    assign w_head     = w_keys[0];
    assign w_kx       = (KEY_CNT_W + 1)'(r_scan_k);
    assign w_nx       = (KEY_CNT_W + 1)'(w_n);
    assign w_in_range = (w_kx < w_nx);
    assign w_is_last  = (w_kx + 1'b1 == w_nx);
    assign w_below    = (r_q < w_head.frame);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q     <= w_query;
            r_stepv <= '0;
            r_brk   <= 1'b0;
            r_found <= 1'b0;
        end else if (w_shift) begin
            r_prev <= w_head;
            // Step curve: key 0, then each later key up to the first whose frame is above the query
            if (r_scan_k == '0) begin
                if (w_in_range) begin
                    r_stepv <= w_head.value;
                end
            end else if (w_in_range && !r_brk) begin
                if (w_below) begin
                    r_brk <= 1'b1;
                end else begin
                    r_stepv <= w_head.value;
                end
            end
            // Hermite: first key, last key and the active segment
            if (r_scan_k == '0) begin
                r_key0 <= w_head;
            end
            if (w_is_last) begin
                r_last <= w_head;
            end
            if (r_scan_k != '0 && !r_found) begin
                if (w_kx + 2'd2 <= w_nx && w_below) begin
                    r_found <= 1'b1;
                    r_seg0  <= r_prev;
                    r_seg1  <= w_head;
                end else if (w_is_last) begin
                    r_seg0 <= r_prev;
                    r_seg1 <= w_head;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Decision: pick the value directly or start the segment division
    // ------------------------------------------------------------------
    logic signed [32:0] w_seg_d;
    logic signed [32:0] w_num;
    logic signed [31:0] w_dec_value;

    assign w_seg_d = {r_seg1.frame[31], r_seg1.frame} - {r_seg0.frame[31], r_seg0.frame};
    assign w_num   = {r_q[31], r_q} - {r_seg0.frame[31], r_seg0.frame};

    always_comb begin
        w_need_div  = 1'b0;
        w_dec_value = '0;
        unique case (r_kind)
            KIND_STEP: w_dec_value = r_stepv;
            KIND_HERMITE: begin
                if (w_n == '0) begin
                    w_dec_value = '0;
                end else if (w_n == KEY_CNT_W'(1) || r_q <= r_key0.frame) begin
                    w_dec_value = r_key0.value;
                end else if (r_q >= r_last.frame) begin
                    w_dec_value = r_last.value;
                end else if (w_seg_d <= 33'sd0) begin
                    w_dec_value = r_seg1.value;
                end else begin
                    w_need_div = 1'b1;
                end
            end
            default: w_dec_value = '0;
        endcase
    end

    kce_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num[31:0]),
        .i_den   (w_seg_d[31:0]),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ------------------------------------------------------------------
    // Hermite arithmetic on one shared multiplier, one product a cycle
    // ------------------------------------------------------------------
    logic [T_FRAC-1:0]  r_t;
    logic [T_FRAC-1:0]  r_t2;
    logic [T_FRAC-1:0]  r_t3;
    logic [31:0]        r_d;
    logic signed [32:0] r_h00;
    logic signed [32:0] r_h10;
    logic signed [32:0] r_h01;
    logic signed [32:0] r_h11;
    logic signed [33:0] r_vp;
    logic signed [33:0] r_sp;
    logic signed [66:0] r_acc;
    logic signed [47:0] r_v;
    logic signed [33:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [66:0] w_prod;
    logic signed [66:0] w_sum;
    logic signed [33:0] w_t1e;
    logic signed [33:0] w_t2e;
    logic signed [33:0] w_t3e;
    logic signed [33:0] w_h00;
    logic signed [33:0] w_h10;
    logic signed [33:0] w_h01;
    logic signed [33:0] w_h11;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_T2: begin
                w_mul_a = $signed(34'(r_t));
                w_mul_b = $signed(33'(r_t));
            end
            S_T3: begin
                w_mul_a = $signed(34'(r_t2));
                w_mul_b = $signed(33'(r_t));
            end
            S_M1: begin
                w_mul_a = 34'(r_h00);
                w_mul_b = 33'(r_seg0.value);
            end
            S_M2: begin
                w_mul_a = 34'(r_h01);
                w_mul_b = 33'(r_seg1.value);
            end
            S_M3: begin
                w_mul_a = 34'(r_h10);
                w_mul_b = 33'(r_seg0.slope);
            end
            S_M4: begin
                w_mul_a = 34'(r_h11);
                w_mul_b = 33'(r_seg1.slope);
            end
            S_M5: begin
                w_mul_a = r_sp;
                w_mul_b = $signed(33'(r_d[15:0]));
            end
            S_M6: begin
                w_mul_a = r_sp;
                w_mul_b = $signed(33'(r_d[31:16]));
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    // High half of the span enters 16 places up
    assign w_sum  = r_acc + ((r_state == S_M6) ? (w_prod <<< 16) : w_prod);

    // Basis weights from t, t^2, t^3 in Q2.30
    assign w_t1e = $signed(34'(r_t));
    assign w_t2e = $signed(34'(r_t2));
    assign w_t3e = $signed(34'(r_t3));
    assign w_h00 = (w_t3e <<< 1) - (w_t2e + (w_t2e <<< 1)) + 34'sh4000_0000;
    assign w_h10 = w_t3e - (w_t2e <<< 1) + w_t1e;
    assign w_h01 = (w_t2e + (w_t2e <<< 1)) - (w_t3e <<< 1);
    assign w_h11 = w_t3e - w_t2e;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_DECIDE: begin
                r_v <= 48'(w_dec_value);
                r_d <= w_seg_d[31:0];
            end
            S_DIV:  r_t  <= w_div_quot;
            S_T2:   r_t2 <= w_prod[59:30];
            S_T3:   r_t3 <= w_prod[59:30];
            S_H: begin
                r_h00 <= w_h00[32:0];
                r_h10 <= w_h10[32:0];
                r_h01 <= w_h01[32:0];
                r_h11 <= w_h11[32:0];
            end
            S_M1:   r_acc <= w_prod;
            // Floor shifts: take the upper bits of the signed sum
            S_M2:   r_vp  <= w_sum[63:30];
            S_M3:   r_acc <= w_prod;
            S_M4:   r_sp  <= w_sum[63:30];
            S_M5:   r_acc <= w_prod;
            S_M6:   r_acc <= w_sum;
            S_SUM:  r_v   <= 48'(r_vp) + $signed(r_acc[63:16]);
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output clamp and result register
    // ------------------------------------------------------------------
    logic signed [47:0] w_neg_v;
    logic [31:0]        w_trunc;
    logic [31:0]        w_res;
    logic               w_sat;
    logic [31:0]        r_out_data;
    logic               r_out_sat;

    assign w_neg_v = -r_v;
    // Integer part, rounded toward zero
    assign w_trunc = r_v[47] ? (32'd0 - w_neg_v[47:16]) : r_v[47:16];

    always_comb begin
        w_res = w_trunc;
        w_sat = 1'b0;
        unique case (r_clamp_mode)
            CLAMP_U8: begin
                if (r_v < 48'sd0) begin
                    w_res = 32'd0;
                    w_sat = 1'b1;
                end else if (r_v > LIM_U8_HI) begin
                    w_res = 32'd255;
                    w_sat = 1'b1;
                end
            end
            CLAMP_S11: begin
                if (r_v < LIM_S11_LO) begin
                    w_res = -32'sd1024;
                    w_sat = 1'b1;
                end else if (r_v > LIM_S11_HI) begin
                    w_res = 32'd1023;
                    w_sat = 1'b1;
                end
            end
            default: begin
                if (r_v > LIM_RAW_HI) begin
                    w_res = 32'h7FFF_FFFF;
                    w_sat = 1'b1;
                end else if (r_v < LIM_RAW_LO) begin
                    w_res = 32'h8000_0000;
                    w_sat = 1'b1;
                end else begin
                    w_res = r_v[31:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_res;
            r_out_sat  <= w_sat;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The ring must be back in slot order whenever writes can land
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_scan_k == '0))
        else $error("key ring not aligned while idle");

    // Waiting on the divider only makes sense while it works or reports
    a_div_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_div_busy || w_div_done))
        else $error("sequencer waits on an idle divider");

    // A finished result always reaches the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || i_m_tready)) |=> o_m_tvalid)
        else $error("result dropped at the output register");

endmodule

// ----- bench/tb_keyframe_curve_evaluator_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_curve_evaluator_unit - self-checking bench of the curve evaluator
// Loads key sets through the stream port, switches curve kind, key count and
// output clamp between phases, and checks every evaluated value and its flag
// against an in-bench fixed-point curve predictor with random stalls.
// ----------------------------------------------------------------------------
module tb_keyframe_curve_evaluator_unit;
    import kce_pkg::*;

    // Curve kind and clamp codes the block treats as defaults
    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_RESERVED  = 2'd3;
    localparam logic [1:0] CLAMP_RESERVED = 2'd3;

    // Holds the pending curve values and compares results in order
    class curve_scoreboard;
        logic [31:0] value_q[$];
        logic        flag_q[$];
        int          errors = 0;

        function void note_item(logic [31:0] v, logic f);
            value_q.push_back(v);
            flag_q.push_back(f);
        endfunction

        function void check_result(logic [31:0] v, logic f);
            logic [31:0] ev;
            logic        ef;
            if (value_q.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h/%b", $time, v, f);
                errors++;
                return;
            end
            ev = value_q.pop_front();
            ef = flag_q.pop_front();
            if (ev !== v) begin
                $display("%0t: curve_value mismatch expected %h actual %h", $time, ev, v);
                errors++;
            end
            if (ef !== f) begin
                $display("%0t: clamped mismatch expected %b actual %b", $time, ef, f);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_s_tvalid = 0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;
    logic [0:0]             i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 0;
    logic [31:0]            o_m_tdata;
    logic [0:0]             o_m_tuser;
    logic                   i_cfg_valid = 0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    keyframe_curve_evaluator_unit DUT (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    initial begin
        #300ms;
        $display("FAILURE");
        $finish;
    end

    curve_scoreboard board = new();

    // Predictor copy of the key store and registers
    logic signed [31:0] frames_m[MAX_KEYS];
    logic signed [31:0] values_m[MAX_KEYS];
    logic signed [31:0] slopes_m[MAX_KEYS];
    logic [6:0] count_m = 0;
    logic [1:0] kind_m = 0;
    logic [1:0] clamp_m = 0;
    bit   quiet = 0;      // no idling in the final stretch
    bit   hold_long = 0;  // receiver long hold-off request

    function automatic longint floor_sh(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint step_value(longint q, int n);
        longint v;
        if (n == 0) return 0;
        v = values_m[0];
        for (int i = 1; i < n; i++) begin
            if (q < frames_m[i]) break;
            v = values_m[i];
        end
        return v;
    endfunction

    function automatic longint hermite_value(longint q, int n);
        int i;
        longint f0, f1, d, t, t2, t3, h00, h10, h01, h11, vp, sp;
        logic [63:0] tu;
        i = 0;
        if (n == 0) return 0;
        if (n == 1 || q <= frames_m[0]) return values_m[0];
        if (q >= frames_m[n-1]) return values_m[n-1];
        while (i + 2 < n && q >= frames_m[i+1]) i++;
        f0 = frames_m[i];
        f1 = frames_m[i+1];
        d = f1 - f0;
        if (d <= 0) return values_m[i+1];
        tu = (64'(q - f0) << 30) / 64'(d);
        t = tu;
        t2 = (tu * tu) >> 30;
        t3 = (64'(t2) * tu) >> 30;
        h00 = 2*t3 - 3*t2 + (64'sd1 << 30);
        h10 = t3 - 2*t2 + t;
        h01 = -2*t3 + 3*t2;
        h11 = t3 - t2;
        vp = floor_sh(h00 * longint'(values_m[i]) + h01 * longint'(values_m[i+1]), 30);
        sp = floor_sh(h10 * longint'(slopes_m[i]) + h11 * longint'(slopes_m[i+1]), 30);
        sp = floor_sh(sp * d, 16);
        return vp + sp;
    endfunction

    function automatic longint trunc_int(longint x);
        return (x >= 0) ? (x >>> 16) : -((-x) >>> 16);
    endfunction

    // Work out one evaluation and queue the expected result
    function automatic void predict_curve(logic signed [31:0] query);
        int n;
        longint v, r;
        logic sat;
        n = (count_m > MAX_KEYS) ? MAX_KEYS : count_m;
        sat = 0;
        if (kind_m == KIND_STEP) v = step_value(query, n);
        else if (kind_m == KIND_HERMITE) v = hermite_value(query, n);
        else v = 0;
        if (clamp_m == CLAMP_U8) begin
            if (v < 0) begin r = 0; sat = 1; end
            else if (v > 255*65536) begin r = 255; sat = 1; end
            else r = trunc_int(v);
        end else if (clamp_m == CLAMP_S11) begin
            if (v < -1024*65536) begin r = -1024; sat = 1; end
            else if (v > 1023*65536) begin r = 1023; sat = 1; end
            else r = trunc_int(v);
        end else begin
            if (v > 64'sd2147483647) begin r = 64'sd2147483647; sat = 1; end
            else if (v < -64'sd2147483648) begin r = -64'sd2147483648; sat = 1; end
            else r = v;
        end
        board.note_item(r[31:0], sat);
    endfunction

    // Drop valid only when idling; back to back items keep it high
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Offer one item and wait for its handshake
    task automatic send_item(logic act, logic [5:0] idx, logic [31:0] fr,
                             logic [31:0] va, logic [31:0] sl, logic [31:0] q);
        i_s_tdata  <= {2'b00, q, sl, va, fr, idx};
        i_s_tuser  <= act;
        i_s_tvalid <= 1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (act == ACT_WRITE) begin
            frames_m[idx] = fr;
            values_m[idx] = va;
            slopes_m[idx] = sl;
        end else begin
            predict_curve(q);
        end
        sender_gap();
    endtask

    task automatic write_key(int idx, logic [31:0] fr, logic [31:0] va, logic [31:0] sl);
        send_item(ACT_WRITE, idx[5:0], fr, va, sl, $urandom());
    endtask

    task automatic evaluate(logic [31:0] q);
        send_item(ACT_EVAL, 6'($urandom()), $urandom(), $urandom(), $urandom(), q);
    endtask

    // Drain, let the block settle, then write one register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
        i_s_tvalid <= 0;
        while (board.value_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            CFG_KEY_COUNT:    count_m = data;
            CFG_CURVE_KIND:   kind_m  = data[1:0];
            CFG_OUTPUT_CLAMP: clamp_m = data[1:0];
            default: ;
        endcase
    endtask

    // Fill all slots with ascending frames, some repeated frames
    task automatic load_keys(int spread);
        int f;
        f = -($urandom_range(0, 40) << 16);
        for (int k = 0; k < MAX_KEYS; k++) begin
            write_key(k, f, $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 2000 << 16)) - (1000 << 16),
                      $signed($urandom_range(0, 1 << 20)) - (1 << 19));
            if ($urandom_range(0, 9) != 0) f += $urandom_range(1, spread);
        end
    endtask

    function automatic logic [31:0] pick_query();
        int n;
        n = (count_m > MAX_KEYS) ? MAX_KEYS : count_m;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return frames_m[$urandom_range(0, n ? n - 1 : 0)];
            default: return frames_m[0] + $urandom_range(0,
                         n ? frames_m[n ? n - 1 : 0] - frames_m[0] + 2 : 10);
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_m_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_long = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_m_tready <= 1;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser[0]);

    initial begin
        logic [6:0] counts[6];
        counts = '{0, 1, 2, 7, 64, 100};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes of keys, every kind and clamp, edge cases
        write_key(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_key(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        write_key(2, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0);
        write_key(63, 32'h0, 32'hFFFF_FFFF, 32'h1);
        write_reg(CFG_CURVE_KIND, KIND_HERMITE);
        write_reg(CFG_KEY_COUNT, 2);
        evaluate(32'h8000_0000);
        evaluate(32'h0);
        evaluate(32'h7FFF_FFFF);
        evaluate(32'h4000_0000);
        write_reg(CFG_KEY_COUNT, 3);
        evaluate(32'h7FFF_FFFE);
        write_reg(CFG_OUTPUT_CLAMP, CLAMP_U8);
        evaluate(32'h8000_0000);
        evaluate(32'h7FFF_FFFF);
        write_reg(CFG_OUTPUT_CLAMP, CLAMP_S11);
        evaluate(32'h8000_0000);
        evaluate(32'h7FFF_FFFF);
        write_reg(CFG_OUTPUT_CLAMP, CLAMP_RESERVED);
        evaluate(32'h1234_5678);
        write_reg(CFG_CURVE_KIND, KIND_STEP);
        evaluate(32'h8000_0000);
        evaluate(32'h7FFF_FFFF);
        write_reg(CFG_CURVE_KIND, KIND_RESERVED);
        evaluate(32'h0);
        write_reg(CFG_CURVE_KIND, KIND_NONE);
        evaluate(32'h0);
        write_reg(CFG_KEY_COUNT, 0);
        write_reg(CFG_CURVE_KIND, KIND_HERMITE);
        evaluate(32'h0);

        // Fill all slots, then random phases
        load_keys(1 << 18);
        for (int ph = 0; ph < 24; ph++) begin
            if (ph == 21) quiet = 1;
            write_reg(CFG_KEY_COUNT, counts[$urandom_range(0, 5)]);
            write_reg(CFG_CURVE_KIND, $urandom_range(0, 3));
            write_reg(CFG_OUTPUT_CLAMP, $urandom_range(0, 3));
            if (ph == 3) hold_long = 1;
            for (int k = 0; k < 60; k++) begin
                if ($urandom_range(0, 7) == 0)
                    write_key($urandom_range(0, 63), $urandom(), $urandom(), $urandom());
                else
                    evaluate(pick_query());
            end
            if (ph % 6 == 5) load_keys($urandom_range(0, 1) ? (1 << 12) : (1 << 24));
        end

        i_s_tvalid <= 0;
        while (board.value_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
